// File: src/dpw_pkg.sv
package dpw_pkg;

  localparam int QUERY_MAX = 256;
  localparam int QIDX_W    = $clog2(QUERY_MAX);
  localparam int QCNT_W    = $clog2(QUERY_MAX + 1);
  localparam int PITCH_W   = 8;
  localparam int OFS_W     = 10;
  localparam int DIFF_W    = OFS_W + 1;
  localparam int LCOST_W   = OFS_W;
  localparam int COST_W    = 24;

  localparam logic [COST_W-1:0] COST_MAX   = {COST_W{1'b1}};
  localparam logic [COST_W-1:0] EMPTY_CODE = COST_W'(99999);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_REF    = 2'd2,
    REQ_END    = 2'd3
  } dpw_req_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [PITCH_W-1:0] pitch_sample;
  } dpw_in_t;

  typedef struct packed {
    logic [COST_W-1:0] match_cost;
    logic              was_empty;
  } dpw_out_t;

  // query sample write, broadcast to every cell
  typedef struct packed {
    logic               en;
    logic [QIDX_W-1:0]  idx;
    logic [PITCH_W-1:0] data;
  } dpw_qwr_t;

  // word handed from one cell to the next
  typedef struct packed {
    logic               vld;
    logic               is_end;
    logic               first;
    logic               empty;
    logic [PITCH_W-1:0] ref_smp;
    logic [QIDX_W-1:0]  tgt;
    logic [COST_W-1:0]  cost;
    logic [COST_W-1:0]  diag;
  } dpw_wave_t;

endpackage

// File: src/dpw_cell.sv
module dpw_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [dpw_pkg::QIDX_W-1:0]            cell_idx,
  input  logic signed [dpw_pkg::OFS_W-1:0]      pitch_offset,
  input  dpw_pkg::dpw_qwr_t                     qwr,
  input  dpw_pkg::dpw_wave_t                    wave_in,
  output dpw_pkg::dpw_wave_t                    wave_out
);
  import dpw_pkg::*;

  logic [PITCH_W-1:0]       q_r;
  logic [COST_W-1:0]        cost_r;
  dpw_wave_t                wave_r;
  dpw_wave_t                wave_nxt;
  logic                     head;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [LCOST_W-1:0]       lcost;
  logic [COST_W-1:0]        min_a;
  logic [COST_W-1:0]        min_b;
  logic [COST_W-1:0]        best;
  logic [COST_W:0]          sum;
  logic [COST_W-1:0]        cost_nxt;
  logic                     upd;

  assign head = (cell_idx == '0);

  always_comb begin
    diff  = $signed({3'b000, wave_in.ref_smp}) - $signed({3'b000, q_r})
            + DIFF_W'(pitch_offset);
    mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    lcost = mag[LCOST_W-1:0];

    min_a = (cost_r < wave_in.diag) ? cost_r : wave_in.diag;
    min_b = (min_a < wave_in.cost) ? min_a : wave_in.cost;
    priority if (wave_in.first) begin
      best = head ? '0 : wave_in.cost;
    end else if (head) begin
      best = cost_r;
    end else begin
      best = min_b;
    end

    sum      = {1'b0, best} + (COST_W + 1)'(lcost);
    cost_nxt = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    upd      = wave_in.vld && !wave_in.is_end;

    wave_nxt = wave_in;
    if (upd) begin
      wave_nxt.cost = cost_nxt;
      wave_nxt.diag = cost_r;
    end else if (wave_in.vld && !wave_in.empty && cell_idx == wave_in.tgt) begin
      // end word picks up the last column's cost
      wave_nxt.cost = cost_r;
    end
  end

  always_ff @(posedge clk) begin
    if (qwr.en && qwr.idx == cell_idx) begin
      q_r <= qwr.data;
    end
    if (upd) begin
      cost_r <= cost_nxt;
    end
    if (!rst_n) begin
      wave_r.vld <= 1'b0;
    end else begin
      wave_r.vld <= wave_nxt.vld;
    end
    wave_r.is_end  <= wave_nxt.is_end;
    wave_r.first   <= wave_nxt.first;
    wave_r.empty   <= wave_nxt.empty;
    wave_r.ref_smp <= wave_nxt.ref_smp;
    wave_r.tgt     <= wave_nxt.tgt;
    wave_r.cost    <= wave_nxt.cost;
    wave_r.diag    <= wave_nxt.diag;
  end

  assign wave_out = wave_r;

endmodule

// File: src/dtw_pitch_distance.sv
// Warping cost engine: a chain of QUERY_MAX cells, one per query column.
// An end word passes through the register of every cell in the chain
// before its result appears on out_strobe and out_data.
// Throughput: one word per cycle of any kind; busy stays low, results cannot be stalled.
// Reset: synchronous, active low; clears query count, started flag, offset and chain valid bits.
module dtw_pitch_distance (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  dpw_pkg::dpw_in_t                  in_data,
  output logic                              out_strobe,
  output dpw_pkg::dpw_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic signed [dpw_pkg::OFS_W-1:0]  cfg_data
);
  import dpw_pkg::*;

  logic signed [OFS_W-1:0] ofs_r;
  logic [QCNT_W-1:0]       qcount_r;
  logic [QCNT_W-1:0]       qcount_nxt;
  logic                    started_r;
  logic                    started_nxt;
  logic                    acc;
  logic [QCNT_W-1:0]       last;
  dpw_qwr_t                qwr;
  dpw_wave_t               inj;
  dpw_wave_t               chain [QUERY_MAX+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;
  assign last      = qcount_r - QCNT_W'(1);

  always_comb begin
    qcount_nxt  = qcount_r;
    started_nxt = started_r;
    qwr.en      = 1'b0;
    qwr.idx     = qcount_r[QIDX_W-1:0];
    qwr.data    = in_data.pitch_sample;
    inj.vld     = 1'b0;
    inj.is_end  = 1'b0;
    inj.first   = !started_r;
    inj.empty   = (qcount_r == '0) || !started_r;
    inj.ref_smp = in_data.pitch_sample;
    inj.tgt     = last[QIDX_W-1:0];
    inj.cost    = '0;
    inj.diag    = '0;
    if (acc) begin
      unique case (dpw_req_t'(in_data.req_type))
        REQ_CLEAR: begin
          qcount_nxt  = '0;
          started_nxt = 1'b0;
        end
        REQ_APPEND: begin
          // drop appends once a reference is running or the query is full
          if (!started_r && qcount_r < QCNT_W'(QUERY_MAX)) begin
            qwr.en     = 1'b1;
            qcount_nxt = qcount_r + QCNT_W'(1);
          end
        end
        REQ_REF: begin
          inj.vld     = 1'b1;
          started_nxt = 1'b1;
        end
        REQ_END: begin
          inj.vld     = 1'b1;
          inj.is_end  = 1'b1;
          inj.cost    = inj.empty ? EMPTY_CODE : '0;
          started_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r     <= '0;
      qcount_r  <= '0;
      started_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ofs_r <= cfg_data;
      end
      qcount_r  <= qcount_nxt;
      started_r <= started_nxt;
    end
  end

  assign chain[0] = inj;

  for (genvar i = 0; i < QUERY_MAX; i++) begin : g_cell
    dpw_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cell_idx     (QIDX_W'(i)),
      .pitch_offset (ofs_r),
      .qwr          (qwr),
      .wave_in      (chain[i]),
      .wave_out     (chain[i+1])
    );
  end

  assign out_strobe          = chain[QUERY_MAX].vld && chain[QUERY_MAX].is_end;
  assign out_data.match_cost = chain[QUERY_MAX].cost;
  assign out_data.was_empty  = chain[QUERY_MAX].empty;

endmodule
